// File: rtl/assert_macros.svh
// Assertion helpers for the RTL; only the queue uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/vtp_pkg.sv
package vtp_pkg;

  localparam int ADDR_BITS = 6;
  localparam int DIV_STEPS = 17;

  localparam logic [2:0] REG_ROW_X    = 3'd0;
  localparam logic [2:0] REG_ROW_Y    = 3'd1;
  localparam logic [2:0] REG_ROW_Z    = 3'd2;
  localparam logic [2:0] REG_CENTER_X = 3'd3;
  localparam logic [2:0] REG_CENTER_Y = 3'd4;

  localparam logic [63:0] ROW_X_RESET = 64'h0000_0000_0000_1000;
  localparam logic [63:0] ROW_Y_RESET = 64'h0000_0000_1000_0000;
  localparam logic [63:0] ROW_Z_RESET = 64'h0000_1000_0000_0000;
  localparam logic [9:0]  CENTER_RESET = 10'd128;

  // Transformed vertex handed from front to back
  typedef struct packed {
    logic [9:0]         idx;
    logic               vis;
    logic               last;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] d;
  } item_t;

  // One quotient in flight: restoring division, one bit a stage
  typedef struct packed {
    logic        neg;
    logic        nonneg;
    logic        ovf;
    logic [15:0] rem;
    logic [16:0] low;
    logic [16:0] q;
  } lane_t;

  typedef struct packed {
    logic [9:0]  idx;
    logic        vis;
    logic        last;
    logic [15:0] d;
    logic        zero;
    logic [15:0] dv;
    lane_t       lx;
    lane_t       ly;
  } bstage_t;

  function automatic lane_t lane_pre(input logic signed [31:0] p,
                                     input logic [15:0] d, input logic [15:0] dv);
    lane_t       l;
    logic [31:0] mag;
    mag      = p[31] ? (32'd0 - p) : p;
    l.neg    = p[31] ^ d[15];
    l.nonneg = !p[31];
    l.ovf    = {1'b0, mag[31:17]} >= dv;
    l.rem    = {1'b0, mag[31:17]};
    l.low    = mag[16:0];
    l.q      = '0;
    return l;
  endfunction

  function automatic lane_t div_step(input lane_t l, input logic [15:0] dv);
    lane_t       n;
    logic [16:0] r;
    logic [16:0] diff;
    n    = l;
    r    = {l.rem, l.low[16]};
    diff = r - {1'b0, dv};
    if (r >= {1'b0, dv}) begin
      n.rem = diff[15:0];
      n.q   = {l.q[15:0], 1'b1};
    end else begin
      n.rem = r[15:0];
      n.q   = {l.q[15:0], 1'b0};
    end
    n.low = {l.low[15:0], 1'b0};
    return n;
  endfunction

  // Saturated signed quotient and error flag
  function automatic logic [16:0] lane_result(input lane_t l, input logic zero);
    logic [15:0] q;
    logic        err;
    err = 1'b0;
    if (zero) begin
      q   = l.nonneg ? 16'h7FFF : 16'h8000;
      err = 1'b1;
    end else if (l.ovf || (!l.neg && l.q > 17'd32767) || (l.neg && l.q > 17'd32768)) begin
      q   = l.neg ? 16'h8000 : 16'h7FFF;
      err = 1'b1;
    end else begin
      q = l.neg ? (16'd0 - l.q[15:0]) : l.q[15:0];
    end
    return {err, q};
  endfunction

endpackage

// File: rtl/vertex_transform_project_top.sv
// Throughput: one vertex per cycle while out_ready does not stall the output;
// the two 17-stage quotient pipelines set the depth.
// A four-entry queue parts the transform stages from the divide stages.
// Synchronous active-high reset empties all stages and the queue and restores
// the matrix rows and screen centres to their defaults.
module vertex_transform_project_top #(
  parameter int FRAC_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vtp_pkg::ADDR_BITS-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [9:0]                   vertex_index,
  input  logic                         visible,
  input  logic signed [15:0]           pos_x,
  input  logic signed [15:0]           pos_y,
  input  logic signed [15:0]           pos_z,
  input  logic                         last_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [9:0]                   out_index,
  output logic                         written,
  output logic signed [15:0]           screen_x,
  output logic signed [15:0]           screen_y,
  output logic signed [15:0]           depth,
  output logic                         divide_error,
  output logic                         last_out
);
  import vtp_pkg::*;

  logic [63:0] row_x, row_y, row_z;
  logic [9:0]  center_x, center_y;
  logic [2:0]  reg_idx;
  logic        push, pop, full, empty;
  item_t       item, head;
  logic [$bits(item_t)-1:0] head_bits;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_BITS-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x    <= ROW_X_RESET;
      row_y    <= ROW_Y_RESET;
      row_z    <= ROW_Z_RESET;
      center_x <= CENTER_RESET;
      center_y <= CENTER_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_ROW_X:    row_x    <= pwdata;
        REG_ROW_Y:    row_y    <= pwdata;
        REG_ROW_Z:    row_z    <= pwdata;
        REG_CENTER_X: center_x <= pwdata[9:0];
        REG_CENTER_Y: center_y <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROW_X:    prdata = row_x;
      REG_ROW_Y:    prdata = row_y;
      REG_ROW_Z:    prdata = row_z;
      REG_CENTER_X: prdata = {54'b0, center_x};
      REG_CENTER_Y: prdata = {54'b0, center_y};
      default:      prdata = '0;
    endcase
  end

  vtp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .vertex_index, .visible,
    .pos_x, .pos_y, .pos_z, .last_in, .row_x, .row_y, .row_z,
    .push, .item, .full
  );

  vtp_fifo #(.W($bits(item_t))) u_fifo (
    .clk, .rst, .push, .wdata(item), .pop, .rdata(head_bits), .full, .empty
  );

  assign head = item_t'(head_bits);

  vtp_back u_back (
    .clk, .rst, .head, .empty, .pop, .center_x, .center_y,
    .out_valid, .out_ready, .out_index, .written, .screen_x, .screen_y,
    .depth, .divide_error, .last_out
  );
endmodule

// File: rtl/vtp_fifo.sv
`include "assert_macros.svh"

module vtp_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  logic [W-1:0] mem [4];
  logic [1:0]   wptr;
  logic [1:0]   rptr;
  logic [2:0]   count;

  assign full  = (count == 3'd4);
  assign empty = (count == 3'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 2'd1;
      if (pop) rptr <= rptr + 2'd1;
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

  `ASSERT_NEVER(a_no_overflow, push && full && !pop, "push into full queue")
  `ASSERT_NEVER(a_no_underflow, pop && empty, "pop from empty queue")
  `ASSERT_CLK(a_ptr_gap, wptr - rptr == count[1:0], "queue pointers disagree with count")
endmodule

// File: rtl/vtp_front.sv
module vtp_front #(
  parameter int FRAC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [9:0]          vertex_index,
  input  logic                visible,
  input  logic signed [15:0]  pos_x,
  input  logic signed [15:0]  pos_y,
  input  logic signed [15:0]  pos_z,
  input  logic                last_in,
  input  logic [63:0]         row_x,
  input  logic [63:0]         row_y,
  input  logic [63:0]         row_z,
  output logic                push,
  output vtp_pkg::item_t      item,
  input  logic                full
);
  import vtp_pkg::*;

  localparam int SH = FRAC_BITS - 8;

  logic [63:0]        rows [3];
  logic signed [15:0] p0 [3];
  logic signed [15:0] p1 [3];
  logic signed [31:0] pp_c [3];
  logic signed [31:0] cz_c [3];
  logic signed [31:0] ab_c [3];
  logic signed [31:0] xy_c;

  logic               v1, v2, en;
  logic [9:0]         idx1;
  logic               vis1, last1;
  logic signed [31:0] pp1 [3];
  logic signed [31:0] cz1 [3];
  logic signed [31:0] ab1 [3];
  logic signed [15:0] t1 [3];
  logic signed [31:0] xy1;
  logic signed [31:0] sum [3];
  logic signed [31:0] scr [2];
  logic signed [31:0] dfull;
  item_t              item2;

  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_z;

  assign en       = !(v2 && full);
  assign in_ready = en;
  assign push     = v2 && !full;
  assign item     = item2;

  always_comb begin
    xy_c = pos_x * pos_y;
    for (int r = 0; r < 3; r++) begin
      p0[r]   = $signed(rows[r][15:0]) + pos_y;
      p1[r]   = $signed(rows[r][31:16]) + pos_x;
      pp_c[r] = p0[r] * p1[r];
      cz_c[r] = $signed(rows[r][47:32]) * pos_z;
      ab_c[r] = $signed(rows[r][15:0]) * $signed(rows[r][31:16]);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = pp1[r] + cz1[r] - xy1;
    end
    for (int r = 0; r < 2; r++) begin
      scr[r] = (sum[r] >>> SH) + $signed({{8{t1[r][15]}}, t1[r], 8'b0}) - (ab1[r] >>> SH);
    end
    dfull = (sum[2] >>> FRAC_BITS) + $signed({{16{t1[2][15]}}, t1[2]})
            - (ab1[2] >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1  <= vertex_index;
      vis1  <= visible;
      last1 <= last_in;
      xy1   <= xy_c;
      for (int r = 0; r < 3; r++) begin
        pp1[r] <= pp_c[r];
        cz1[r] <= cz_c[r];
        ab1[r] <= ab_c[r];
        t1[r]  <= $signed(rows[r][63:48]);
      end
      item2.idx  <= idx1;
      item2.vis  <= vis1;
      item2.last <= last1;
      item2.px   <= scr[0];
      item2.py   <= scr[1];
      item2.d    <= dfull[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end
endmodule

// File: rtl/vtp_back.sv
module vtp_back (
  input  logic               clk,
  input  logic               rst,
  input  vtp_pkg::item_t     head,
  input  logic               empty,
  output logic               pop,
  input  logic [9:0]         center_x,
  input  logic [9:0]         center_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         out_index,
  output logic               written,
  output logic signed [15:0] screen_x,
  output logic signed [15:0] screen_y,
  output logic signed [15:0] depth,
  output logic               divide_error,
  output logic               last_out
);
  import vtp_pkg::*;

  bstage_t     stg [DIV_STEPS+1];
  bstage_t     stg_next [DIV_STEPS+1];
  logic        sv [DIV_STEPS+1];
  bstage_t     pre;
  logic        en;
  logic [15:0] dv;
  logic [16:0] rx, ry;
  bstage_t     fin;

  assign en  = !out_valid || out_ready;
  assign pop = en && !empty;
  assign dv  = head.d[15] ? (16'd0 - head.d) : head.d;
  assign fin = stg[DIV_STEPS];
  assign rx  = lane_result(fin.lx, fin.zero);
  assign ry  = lane_result(fin.ly, fin.zero);

  always_comb begin
    pre.idx  = head.idx;
    pre.vis  = head.vis;
    pre.last = head.last;
    pre.d    = head.d;
    pre.zero = (head.d == 16'd0);
    pre.dv   = dv;
    pre.lx   = lane_pre(head.px, head.d, dv);
    pre.ly   = lane_pre(head.py, head.d, dv);
  end

  always_comb begin
    stg_next[0] = pre;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      stg_next[k]    = stg[k-1];
      stg_next[k].lx = div_step(stg[k-1].lx, stg[k-1].dv);
      stg_next[k].ly = div_step(stg[k-1].ly, stg[k-1].dv);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= DIV_STEPS; k++) stg[k] <= stg_next[k];
      out_index <= fin.idx;
      written   <= fin.vis;
      last_out  <= fin.last;
      if (fin.vis) begin
        screen_x     <= rx[15:0] + {6'b0, center_x};
        screen_y     <= ry[15:0] + {6'b0, center_y};
        depth        <= fin.d;
        divide_error <= rx[16] | ry[16];
      end else begin
        screen_x     <= '0;
        screen_y     <= '0;
        depth        <= '0;
        divide_error <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) sv[k] <= 1'b0;
    end else if (en) begin
      sv[0] <= !empty;
      for (int k = 1; k <= DIV_STEPS; k++) sv[k] <= sv[k-1];
      out_valid <= sv[DIV_STEPS];
    end
  end
endmodule
